// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the deframer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/crcdf_pkg.sv =====
package crcdf_pkg;

    // Sizes of the packet store and its fields.
    localparam int MAX_PAYLOAD   = 62;
    localparam int TRAILER_BYTES = 2;
    localparam int STORE_DEPTH   = 64;
    localparam int ADDR_W        = 6;
    localparam int LEN_W         = 6;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 3;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_STATS = 2'd2;

    // Kinds of an output transaction.
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATS   = 2'd2;
    localparam logic [1:0] KIND_NODATA  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HCRC_POLY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HCRC_SEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BCRC_POLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BCRC_SEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_LIMIT = 3'd5;

    // Configuration values after reset.
    localparam logic [7:0]       PREFIX_RESET    = 8'd170;
    localparam logic [7:0]       HCRC_POLY_RESET = 8'd55;
    localparam logic [7:0]       HCRC_SEED_RESET = 8'd66;
    localparam logic [15:0]      BCRC_POLY_RESET = 16'd15717;
    localparam logic [15:0]      BCRC_SEED_RESET = 16'd4919;
    localparam logic [LEN_W-1:0] LEN_LIMIT_RESET = 6'd62;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] request_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic             accepted;
        logic             packet_ready;
        logic [LEN_W-1:0] packet_length;
        logic [7:0]       payload_byte;
        logic             last_byte;
        logic [31:0]      messages_count;
        logic [31:0]      bytes_count;
        logic [31:0]      error_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic exec_item;
        logic pop_emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       hdr_check;
        logic       pop_stream;
        logic       out_free;
        logic       pop_last;
    } t_dp_status;

    // One byte of an MSB-first CRC-8, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        int         i;
        c = crc ^ b;
        for (i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    // One byte of an MSB-first CRC-16, no reflection.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc_checked_packet_deframer.sv =====
// Channel   Direction  Signals                           Contents
// in        input      i_in_valid / o_in_ready           action, data byte, request count
// out       output     o_out_valid / i_out_ready         one result per transaction or popped byte
// cfg       input      i_cfg_wr_en, i_cfg_index, wdata   six registers, write only
//
// A push, a statistics read or a pop with no data is taken in ST_IDLE and
// executed into the output register from ST_EXEC.
// The header CRC byte also passes ST_HDR; its CRC-8 is finished from r_hcrc_mid.
// A pop of n bytes streams them from ST_POP, one packet store read per byte.
// Reset is synchronous and active low; there is no clearing pass.
// A full output register holds the block until the result is taken.
module crc_checked_packet_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [crcdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcdf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  crcdf_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output crcdf_pkg::t_out_item             o_out_item
);
    import crcdf_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Transaction sequencer.
    crcdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Framing, CRC checks, packet store and counters.
    crcdf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

// ===== rtl/core/crcdf_ctrl.sv =====
module crcdf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  crcdf_pkg::t_dp_status i_status,
    output crcdf_pkg::t_dp_cmd    o_cmd
);
    import crcdf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_HDR  = 4'b0100,
        ST_POP  = 4'b1000
    } t_ctl_state;

    t_ctl_state r_state, n_state;

    // Sequencing of one transaction: latch, execute, and stream a pop.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.action)
                    ACT_PUSH: begin
                        if (i_status.hdr_check) begin
                            // The header CRC byte goes through ST_HDR first.
                            n_state = ST_HDR;
                        end else if (i_status.out_free) begin
                            o_cmd.exec_item = 1'b1;
                            n_state         = ST_IDLE;
                        end
                    end
                    ACT_POP: begin
                        if (i_status.pop_stream) begin
                            o_cmd.exec_item = 1'b1;
                            n_state         = ST_POP;
                        end else if (i_status.out_free) begin
                            o_cmd.exec_item = 1'b1;
                            n_state         = ST_IDLE;
                        end
                    end
                    ACT_STATS: begin
                        if (i_status.out_free) begin
                            o_cmd.exec_item = 1'b1;
                            n_state         = ST_IDLE;
                        end
                    end
                    default: begin
                        // The unused action code does nothing.
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.exec_item = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_POP: begin
                if (i_status.out_free) begin
                    o_cmd.pop_emit = 1'b1;
                    if (i_status.pop_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== rtl/core/crcdf_datapath.sv =====
module crcdf_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [crcdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crcdf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  crcdf_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output crcdf_pkg::t_out_item                  o_out_item,
    input  crcdf_pkg::t_dp_cmd                    i_cmd,
    output crcdf_pkg::t_dp_status                 o_status
);
    import crcdf_pkg::*;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_HCRC  = 5'b00100,
        PH_BODY  = 5'b01000,
        PH_READY = 5'b10000
    } t_phase;

    // Configuration registers.
    logic [7:0]       r_cfg_prefix;
    logic [7:0]       r_cfg_hcrc_poly;
    logic [7:0]       r_cfg_hcrc_seed;
    logic [15:0]      r_cfg_bcrc_poly;
    logic [15:0]      r_cfg_bcrc_seed;
    logic [LEN_W-1:0] r_cfg_len_limit;

    // Deframer state.
    t_phase            r_phase, n_phase;
    logic [7:0]        r_hdr_len, n_hdr_len;
    logic [LEN_W-1:0]  r_length_held, n_length_held;
    logic [ADDR_W-1:0] r_bytes_stored, n_bytes_stored;
    logic [15:0]       r_body_crc, n_body_crc;
    logic [31:0]       r_good, n_good;
    logic [31:0]       r_seen, n_seen;
    logic [31:0]       r_bad, n_bad;
    logic [7:0]        r_hcrc_mid;
    t_in_item          r_item;

    // Pop streaming.
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_store [STORE_DEPTH];

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;

    logic              out_load;
    logic              out_free;
    logic              store_we;
    logic [7:0]        hcrc_val;
    logic [15:0]       bcrc_next;
    logic [LEN_W-1:0]  pop_n;
    logic              hdr_ok;
    logic              body_done;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_prefix    <= PREFIX_RESET;
            r_cfg_hcrc_poly <= HCRC_POLY_RESET;
            r_cfg_hcrc_seed <= HCRC_SEED_RESET;
            r_cfg_bcrc_poly <= BCRC_POLY_RESET;
            r_cfg_bcrc_seed <= BCRC_SEED_RESET;
            r_cfg_len_limit <= LEN_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PREFIX:    r_cfg_prefix    <= i_cfg_wdata[7:0];
                REG_HCRC_POLY: r_cfg_hcrc_poly <= i_cfg_wdata[7:0];
                REG_HCRC_SEED: r_cfg_hcrc_seed <= i_cfg_wdata[7:0];
                REG_BCRC_POLY: r_cfg_bcrc_poly <= i_cfg_wdata;
                REG_BCRC_SEED: r_cfg_bcrc_seed <= i_cfg_wdata;
                REG_LEN_LIMIT: r_cfg_len_limit <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The CRC-8 over the prefix depends on configuration alone, so it is
    // registered every cycle and finished with the length byte later.
    always_ff @(posedge i_clk) begin
        r_hcrc_mid <= crc8_byte(r_cfg_hcrc_seed, r_cfg_prefix, r_cfg_hcrc_poly);
    end

    assign hcrc_val  = crc8_byte(r_hcrc_mid, r_hdr_len, r_cfg_hcrc_poly);
    assign bcrc_next = crc16_byte(r_body_crc, r_item.data_byte, r_cfg_bcrc_poly);
    assign pop_n     = (r_item.request_count < r_length_held) ? r_item.request_count
                                                              : r_length_held;
    assign hdr_ok    = (hcrc_val == r_item.data_byte)
                    && (r_hdr_len <= {2'b00, r_cfg_len_limit})
                    && (r_hdr_len <= 8'(MAX_PAYLOAD));
    // The last trailer byte sits at the stored length plus one.
    assign body_done = ({1'b0, r_bytes_stored}
                        >= ({1'b0, r_length_held} + 7'(TRAILER_BYTES - 1)));
    assign out_free  = !r_out_valid || i_out_ready;

    // Status toward the controller.
    always_comb begin
        o_status.action     = r_item.action;
        o_status.hdr_check  = (r_item.action == ACT_PUSH) && (r_phase == PH_HCRC);
        o_status.pop_stream = (r_item.action == ACT_POP) && (r_phase == PH_READY)
                           && (pop_n != '0);
        o_status.out_free   = out_free;
        o_status.pop_last   = ((r_idx + ADDR_W'(1)) == r_cnt);
    end

    // Execution of the latched transaction and of each popped byte.
    always_comb begin
        n_phase        = r_phase;
        n_hdr_len      = r_hdr_len;
        n_length_held  = r_length_held;
        n_bytes_stored = r_bytes_stored;
        n_body_crc     = r_body_crc;
        n_good         = r_good;
        n_seen         = r_seen;
        n_bad          = r_bad;
        n_idx          = r_idx;
        n_cnt          = r_cnt;
        store_we       = 1'b0;
        out_load       = 1'b0;
        n_out_item     = '0;

        if (i_cmd.exec_item) begin
            case (r_item.action)
                ACT_PUSH: begin
                    out_load               = 1'b1;
                    n_out_item.result_kind = KIND_PUSH;
                    // A waiting packet refuses the byte and counts nothing.
                    if (r_phase != PH_READY) begin
                        n_out_item.accepted = 1'b1;
                        n_seen              = r_seen + 32'd1;
                        case (r_phase)
                            PH_HUNT: begin
                                if (r_item.data_byte == r_cfg_prefix) begin
                                    n_phase = PH_LEN;
                                end
                            end
                            PH_LEN: begin
                                n_hdr_len     = r_item.data_byte;
                                n_length_held = (r_item.data_byte > 8'd63) ? 6'd63
                                              : r_item.data_byte[LEN_W-1:0];
                                n_phase       = PH_HCRC;
                            end
                            PH_HCRC: begin
                                if (hdr_ok) begin
                                    n_phase        = PH_BODY;
                                    n_bytes_stored = '0;
                                    n_body_crc     = r_cfg_bcrc_seed;
                                end else begin
                                    n_phase = PH_HUNT;
                                    n_bad   = r_bad + 32'd1;
                                end
                            end
                            PH_BODY: begin
                                store_we   = 1'b1;
                                n_body_crc = bcrc_next;
                                if (body_done) begin
                                    // Zero residue over payload and trailer.
                                    if (bcrc_next == 16'd0) begin
                                        n_phase = PH_READY;
                                        n_good  = r_good + 32'd1;
                                    end else begin
                                        n_phase = PH_HUNT;
                                        n_bad   = r_bad + 32'd1;
                                    end
                                end else begin
                                    n_bytes_stored = r_bytes_stored + ADDR_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_POP: begin
                    if ((r_phase == PH_READY) && (pop_n != '0)) begin
                        // Start streaming; the stored length never exceeds
                        // the payload maximum once a packet is ready.
                        n_phase = PH_HUNT;
                        n_cnt   = pop_n;
                        n_idx   = '0;
                    end else begin
                        out_load               = 1'b1;
                        n_out_item.result_kind = KIND_NODATA;
                        n_out_item.last_byte   = 1'b1;
                        if (r_phase == PH_READY) begin
                            n_phase = PH_HUNT;
                        end
                    end
                end
                ACT_STATS: begin
                    out_load                  = 1'b1;
                    n_out_item.result_kind    = KIND_STATS;
                    n_out_item.messages_count = r_good;
                    n_out_item.bytes_count    = r_seen;
                    n_out_item.error_count    = r_bad;
                    n_good                    = '0;
                    n_seen                    = '0;
                    n_bad                     = '0;
                end
                default: ;
            endcase
        end else if (i_cmd.pop_emit) begin
            out_load                = 1'b1;
            n_out_item.result_kind  = KIND_PAYLOAD;
            n_out_item.payload_byte = r_rd_data;
            n_out_item.last_byte    = o_status.pop_last;
            n_idx                   = r_idx + ADDR_W'(1);
        end

        n_out_item.packet_ready  = (n_phase == PH_READY);
        n_out_item.packet_length = n_length_held;
    end

    // Output register handshake.
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_length_held <= '0;
            r_good        <= '0;
            r_seen        <= '0;
            r_bad         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_length_held <= n_length_held;
            r_good        <= n_good;
            r_seen        <= n_seen;
            r_bad         <= n_bad;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_hdr_len      <= n_hdr_len;
        r_bytes_stored <= n_bytes_stored;
        r_body_crc     <= n_body_crc;
        r_idx          <= n_idx;
        r_cnt          <= n_cnt;
        if (i_cmd.take_item) begin
            r_item <= i_in_item;
        end
        if (out_load) begin
            r_out_item <= n_out_item;
        end
    end

    // Packet store: one write port, one registered read that follows the
    // next pop index.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_bytes_stored] <= r_item.data_byte;
        end
        r_rd_data <= r_store[n_idx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/crcdf_checker.sv =====
`include "assert_macros.svh"

module crcdf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input crcdf_pkg::t_out_item o_out_item
);
    import crcdf_pkg::*;

    // A waiting result holds until it is taken.
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "output result changed while stalled")

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A taken transaction keeps the input closed for its execution.
    `ASSERT_CLK(a_in_busy, i_in_valid && o_in_ready |=> !o_in_ready, "input open right after a transaction")

    // While a pop run is unfinished, no new transaction is taken.
    `ASSERT_CLK(a_pop_run, o_out_valid && (o_out_item.result_kind == KIND_PAYLOAD) && !o_out_item.last_byte |-> !o_in_ready, "input open during a pop run")

endmodule

bind crc_checked_packet_deframer crcdf_checker u_crcdf_checker (.*);
